>>> sv/resonant_multipole_clip_filter_top_defines.svh
// assertion macros of the resonant multipole clip filter rtl, included by the sequencer
`ifndef RESONANT_MULTIPOLE_CLIP_FILTER_TOP_DEFINES_SVH
`define RESONANT_MULTIPOLE_CLIP_FILTER_TOP_DEFINES_SVH

// same-cycle implication, checked on clk with reset held off
`define RMCF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on clk with reset held off
`define RMCF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/rmcf_pkg.sv
// types, constants and microcode field codes of the resonant multipole clip filter
package rmcf_pkg;

  localparam int INTERNAL_WIDTH_DEF = 24;
  localparam int COEF_W             = 16;
  localparam int SAMPLE_W           = 16;
  localparam int CFG_IDX_W          = 4;

  // 0.33 in unsigned q0.16
  localparam logic [COEF_W-1:0] SCALE_033 = 16'd21627;

  localparam int NUM_STEPS = 23;
  localparam int STEP_W    = $clog2(NUM_STEPS);

  localparam logic [STEP_W-1:0] STEP_IDLE = STEP_W'(0);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(NUM_STEPS - 1);

  localparam logic [CFG_IDX_W-1:0] REG_COEF_LOWPASS_A = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_COEF_LOWPASS_B = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_COEF_HIGHPASS  = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_RESONANCE_GAIN = CFG_IDX_W'(3);

  typedef enum logic [3:0] {
    S_ZERO, S_X, S_FB, S_LA0, S_LA1, S_LB0, S_LB1,
    S_HPO, S_HPI, S_Q, S_IN0, S_SA, S_T
  } src_t;

  typedef enum logic [3:0] {
    D_NONE, D_T, D_FB, D_LA0, D_LA1, D_LB0, D_LB1,
    D_HPO, D_HPI, D_Q, D_IN0, D_SA, D_OUT
  } dst_t;

  typedef enum logic [1:0] {PP_WIDE, PP_SAT, PP_CLIP, PP_OUT} post_t;

  typedef enum logic [1:0] {SH_16, SH_15, SH_OUT} shift_t;

  typedef enum logic [2:0] {CS_A, CS_B, CS_HP, CS_RES, CS_033} coef_t;

  typedef enum logic [1:0] {JC_NEXT, JC_WAIT_IN, JC_WAIT_OUT} jump_t;

  typedef struct packed {
    src_t   src_a;
    src_t   src_b;
    logic   b_neg;
    logic   use_prod;
    shift_t shift;
    post_t  post;
    dst_t   dst;
    logic   mul_en;
    coef_t  coef;
    jump_t  jump;
  } ctrl_t;

  typedef struct packed {
    logic load_in;
    logic exec;
  } seq_ctl_t;

endpackage

>>> sv/rmcf_ucode_rom.sv
// microcode program of the filter: one control word per step
module rmcf_ucode_rom (
  input  logic [rmcf_pkg::STEP_W-1:0] step_i,
  output rmcf_pkg::ctrl_t             ctrl_o
);
  import rmcf_pkg::*;

  function automatic ctrl_t cw(src_t a, src_t b, logic neg, logic up, shift_t sh,
                               post_t pp, dst_t d, logic mul, coef_t c, jump_t j);
    ctrl_t w;
    w.src_a    = a;
    w.src_b    = b;
    w.b_neg    = neg;
    w.use_prod = up;
    w.shift    = sh;
    w.post     = pp;
    w.dst      = d;
    w.mul_en   = mul;
    w.coef     = c;
    w.jump     = j;
    return w;
  endfunction

  always_comb begin
    case (step_i)
      // wait for a word
      5'd0:  ctrl_o = cw(S_ZERO, S_ZERO, 1'b0, 1'b0, SH_16, PP_SAT, D_NONE, 1'b0, CS_A, JC_WAIT_IN);
      // cascade input: feedback plus sample
      5'd1:  ctrl_o = cw(S_FB,   S_X,    1'b0, 1'b0, SH_16, PP_SAT, D_IN0,  1'b0, CS_A, JC_NEXT);
      5'd2:  ctrl_o = cw(S_IN0,  S_LA0,  1'b1, 1'b0, SH_16, PP_SAT, D_NONE, 1'b1, CS_A, JC_NEXT);
      5'd3:  ctrl_o = cw(S_LA0,  S_ZERO, 1'b0, 1'b1, SH_16, PP_SAT, D_LA0,  1'b0, CS_A, JC_NEXT);
      5'd4:  ctrl_o = cw(S_LA0,  S_FB,   1'b0, 1'b0, SH_16, PP_SAT, D_Q,    1'b0, CS_A, JC_NEXT);
      5'd5:  ctrl_o = cw(S_Q,    S_LA1,  1'b1, 1'b0, SH_16, PP_SAT, D_NONE, 1'b1, CS_A, JC_NEXT);
      5'd6:  ctrl_o = cw(S_LA1,  S_ZERO, 1'b0, 1'b1, SH_16, PP_SAT, D_LA1,  1'b0, CS_A, JC_NEXT);
      5'd7:  ctrl_o = cw(S_IN0,  S_LB0,  1'b1, 1'b0, SH_16, PP_SAT, D_NONE, 1'b1, CS_B, JC_NEXT);
      5'd8:  ctrl_o = cw(S_LB0,  S_ZERO, 1'b0, 1'b1, SH_16, PP_SAT, D_LB0,  1'b0, CS_B, JC_NEXT);
      5'd9:  ctrl_o = cw(S_LB0,  S_LB1,  1'b1, 1'b0, SH_16, PP_SAT, D_NONE, 1'b1, CS_B, JC_NEXT);
      5'd10: ctrl_o = cw(S_LB1,  S_ZERO, 1'b0, 1'b1, SH_16, PP_SAT, D_LB1,  1'b0, CS_B, JC_NEXT);
      // clipped cascade sum, then highpass input
      5'd11: ctrl_o = cw(S_LA1,  S_LB1,  1'b0, 1'b0, SH_16, PP_CLIP, D_SA,  1'b0, CS_A, JC_NEXT);
      5'd12: ctrl_o = cw(S_X,    S_SA,   1'b0, 1'b0, SH_16, PP_SAT, D_Q,    1'b0, CS_A, JC_NEXT);
      5'd13: ctrl_o = cw(S_Q,    S_HPO,  1'b0, 1'b0, SH_16, PP_WIDE, D_T,   1'b0, CS_A, JC_NEXT);
      5'd14: ctrl_o = cw(S_T,    S_HPI,  1'b1, 1'b0, SH_16, PP_SAT, D_NONE, 1'b1, CS_HP, JC_NEXT);
      5'd15: ctrl_o = cw(S_Q,    S_ZERO, 1'b0, 1'b0, SH_16, PP_SAT, D_HPI,  1'b0, CS_HP, JC_NEXT);
      5'd16: ctrl_o = cw(S_ZERO, S_ZERO, 1'b0, 1'b1, SH_16, PP_SAT, D_HPO,  1'b0, CS_HP, JC_NEXT);
      // next feedback
      5'd17: ctrl_o = cw(S_HPO,  S_ZERO, 1'b0, 1'b0, SH_16, PP_CLIP, D_Q,   1'b0, CS_RES, JC_NEXT);
      5'd18: ctrl_o = cw(S_Q,    S_ZERO, 1'b0, 1'b0, SH_16, PP_SAT, D_NONE, 1'b1, CS_RES, JC_NEXT);
      5'd19: ctrl_o = cw(S_ZERO, S_ZERO, 1'b0, 1'b1, SH_15, PP_CLIP, D_FB,  1'b0, CS_RES, JC_NEXT);
      // output taps
      5'd20: ctrl_o = cw(S_HPO,  S_SA,   1'b0, 1'b0, SH_16, PP_WIDE, D_T,   1'b0, CS_033, JC_NEXT);
      5'd21: ctrl_o = cw(S_T,    S_LA1,  1'b0, 1'b0, SH_16, PP_SAT, D_NONE, 1'b1, CS_033, JC_NEXT);
      5'd22: ctrl_o = cw(S_ZERO, S_ZERO, 1'b0, 1'b1, SH_OUT, PP_OUT, D_OUT, 1'b0, CS_033,
                         JC_WAIT_OUT);
      default: ctrl_o = cw(S_ZERO, S_ZERO, 1'b0, 1'b0, SH_16, PP_SAT, D_NONE, 1'b0, CS_A,
                           JC_NEXT);
    endcase
  end

endmodule

>>> sv/rmcf_sequencer.sv
// step counter and jump logic of the microcode sequencer
module rmcf_sequencer (
  input  logic                        clk,
  input  logic                        rst_n,
  input  rmcf_pkg::ctrl_t             ctrl_i,
  input  logic                        in_valid,
  input  logic                        out_busy_i,
  output logic                        in_ready,
  output logic [rmcf_pkg::STEP_W-1:0] step_o,
  output rmcf_pkg::seq_ctl_t          seq_o
);
  import rmcf_pkg::*;

  `include "resonant_multipole_clip_filter_top_defines.svh"

  logic [STEP_W-1:0] step_r;
  logic [STEP_W-1:0] step_nxt;
  logic              exec;

  always_comb begin
    exec     = 1'b1;
    step_nxt = step_r + STEP_W'(1);
    unique case (ctrl_i.jump)
      JC_WAIT_IN: begin
        if (!in_valid) begin
          step_nxt = step_r;
        end
      end
      JC_WAIT_OUT: begin
        // result slot still full: hold the last step
        if (out_busy_i) begin
          exec     = 1'b0;
          step_nxt = step_r;
        end else begin
          step_nxt = STEP_IDLE;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= STEP_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

  // no word is taken while reset is held
  assign in_ready      = rst_n && (step_r == STEP_IDLE);
  assign step_o        = step_r;
  assign seq_o.load_in = in_ready & in_valid;
  assign seq_o.exec    = exec;

  `RMCF_ASSERT_IMP(a_step_range, 1'b1, step_r <= STEP_LAST, "step counter out of program")
  `RMCF_ASSERT_NXT(a_load_starts, seq_o.load_in, step_r == STEP_W'(1), "word not started")
  `RMCF_ASSERT_NXT(a_hold_last, (step_r == STEP_LAST) && out_busy_i, step_r == STEP_LAST,
                   "last step left with result slot full")
  `RMCF_ASSERT_IMP(a_stall_cause, !exec, out_busy_i && (step_r == STEP_LAST),
                   "step stalled without a full result slot")

endmodule

>>> sv/rmcf_datapath.sv
// filter datapath: state and temporaries, adder with clamps, shared multiplier
module rmcf_datapath #(
  parameter int INTERNAL_WIDTH = rmcf_pkg::INTERNAL_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  rmcf_pkg::ctrl_t                      ctrl_i,
  input  rmcf_pkg::seq_ctl_t                   seq_i,
  input  logic signed [rmcf_pkg::SAMPLE_W-1:0] in_sample_in,
  input  logic                                 cfg_wr_en,
  input  logic [rmcf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [rmcf_pkg::COEF_W-1:0]          cfg_data,
  input  logic                                 out_ready,
  output logic                                 out_valid,
  output logic signed [rmcf_pkg::SAMPLE_W-1:0] out_sample_out,
  output logic                                 out_busy_o
);
  import rmcf_pkg::*;

  localparam int W    = INTERNAL_WIDTH;
  localparam int FRAC = W - 5;
  localparam int AW   = W + 4;
  localparam int MW   = W + 2;
  localparam int PW   = MW + COEF_W + 1;
  localparam int XSHL = (FRAC >= 15) ? FRAC - 15 : 0;
  localparam int XSHR = (FRAC < 15) ? 15 - FRAC : 0;
  localparam int SHOUT = FRAC + 1;

  localparam logic signed [AW-1:0] SAT_MAX = {5'b00000, {(W-1){1'b1}}};
  localparam logic signed [AW-1:0] SAT_MIN = {5'b11111, {(W-1){1'b0}}};
  localparam logic signed [AW-1:0] ONE_Q   = AW'(1) <<< FRAC;
  localparam logic signed [AW-1:0] NEG_ONE = -ONE_Q;
  localparam logic signed [AW-1:0] OUT_MAX = AW'(32767);
  localparam logic signed [AW-1:0] OUT_MIN = -AW'(32768);

  logic [COEF_W-1:0] coef_a_r, coef_b_r, coef_hp_r, res_gain_r;

  logic signed [W-1:0] fb_r, la0_r, la1_r, lb0_r, lb1_r, hpo_r, hpi_r;
  logic signed [W-1:0] x_r, in0_r, q_r, sa_r;
  logic signed [MW-1:0] t_r;
  logic signed [PW-1:0] prod_r;
  logic signed [SAMPLE_W-1:0] out_sample_r;
  logic out_valid_r;

  logic signed [W-1:0]  x_conv;
  logic signed [AW-1:0] op_a, op_b, b_eff, psh_a, sum;
  logic signed [PW-1:0] psh;
  logic signed [MW-1:0] mul_op;
  logic signed [COEF_W:0] coef_s;
  logic [COEF_W-1:0]    coef_sel;
  logic signed [PW-1:0] prod_w;
  logic signed [AW-1:0] clamped;
  logic signed [W-1:0]  res_w;
  logic                 out_wr;

  // q1.15 sample into the internal format
  assign x_conv = (W'(in_sample_in) <<< XSHL) >>> XSHR;

  always_comb begin
    case (ctrl_i.src_a)
      S_X:     op_a = AW'(x_r);
      S_FB:    op_a = AW'(fb_r);
      S_LA0:   op_a = AW'(la0_r);
      S_LA1:   op_a = AW'(la1_r);
      S_LB0:   op_a = AW'(lb0_r);
      S_LB1:   op_a = AW'(lb1_r);
      S_HPO:   op_a = AW'(hpo_r);
      S_HPI:   op_a = AW'(hpi_r);
      S_Q:     op_a = AW'(q_r);
      S_IN0:   op_a = AW'(in0_r);
      S_SA:    op_a = AW'(sa_r);
      S_T:     op_a = AW'(t_r);
      default: op_a = '0;
    endcase
    case (ctrl_i.src_b)
      S_X:     op_b = AW'(x_r);
      S_FB:    op_b = AW'(fb_r);
      S_LA0:   op_b = AW'(la0_r);
      S_LA1:   op_b = AW'(la1_r);
      S_LB0:   op_b = AW'(lb0_r);
      S_LB1:   op_b = AW'(lb1_r);
      S_HPO:   op_b = AW'(hpo_r);
      S_HPI:   op_b = AW'(hpi_r);
      S_Q:     op_b = AW'(q_r);
      S_IN0:   op_b = AW'(in0_r);
      S_SA:    op_b = AW'(sa_r);
      S_T:     op_b = AW'(t_r);
      default: op_b = '0;
    endcase
  end

  // arithmetic shift floors, as the coefficient multiplies require
  always_comb begin
    case (ctrl_i.shift)
      SH_15:   psh = prod_r >>> 15;
      SH_OUT:  psh = prod_r >>> SHOUT;
      default: psh = prod_r >>> 16;
    endcase
  end

  assign psh_a = psh[AW-1:0];
  assign b_eff = ctrl_i.b_neg ? -op_b : op_b;
  assign sum   = op_a + b_eff + (ctrl_i.use_prod ? psh_a : '0);

  always_comb begin
    case (ctrl_i.post)
      PP_CLIP: clamped = (sum > ONE_Q) ? ONE_Q : ((sum < NEG_ONE) ? NEG_ONE : sum);
      PP_OUT:  clamped = (sum > OUT_MAX) ? OUT_MAX : ((sum < OUT_MIN) ? OUT_MIN : sum);
      default: clamped = (sum > SAT_MAX) ? SAT_MAX : ((sum < SAT_MIN) ? SAT_MIN : sum);
    endcase
  end

  assign res_w = clamped[W-1:0];

  always_comb begin
    case (ctrl_i.coef)
      CS_A:    coef_sel = coef_a_r;
      CS_B:    coef_sel = coef_b_r;
      CS_HP:   coef_sel = coef_hp_r;
      CS_RES:  coef_sel = res_gain_r;
      default: coef_sel = SCALE_033;
    endcase
  end

  assign coef_s = $signed({1'b0, coef_sel});
  assign mul_op = sum[MW-1:0];
  assign prod_w = mul_op * coef_s;

  assign out_wr     = seq_i.exec && (ctrl_i.dst == D_OUT);
  assign out_busy_o = out_valid_r & ~out_ready;

  // filter state, configuration and result handshake
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_a_r    <= '0;
      coef_b_r    <= '0;
      coef_hp_r   <= '0;
      res_gain_r  <= '0;
      fb_r        <= '0;
      la0_r       <= '0;
      la1_r       <= '0;
      lb0_r       <= '0;
      lb1_r       <= '0;
      hpo_r       <= '0;
      hpi_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_COEF_LOWPASS_A: coef_a_r   <= cfg_data;
          REG_COEF_LOWPASS_B: coef_b_r   <= cfg_data;
          REG_COEF_HIGHPASS:  coef_hp_r  <= cfg_data;
          REG_RESONANCE_GAIN: res_gain_r <= cfg_data;
          default: ;
        endcase
      end
      if (seq_i.exec) begin
        case (ctrl_i.dst)
          D_FB:    fb_r  <= res_w;
          D_LA0:   la0_r <= res_w;
          D_LA1:   la1_r <= res_w;
          D_LB0:   lb0_r <= res_w;
          D_LB1:   lb1_r <= res_w;
          D_HPO:   hpo_r <= res_w;
          D_HPI:   hpi_r <= res_w;
          default: ;
        endcase
      end
      if (out_wr) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // temporaries, product and result word
  always_ff @(posedge clk) begin
    if (seq_i.load_in) begin
      x_r <= x_conv;
    end
    if (seq_i.exec) begin
      case (ctrl_i.dst)
        D_T:     t_r          <= sum[MW-1:0];
        D_Q:     q_r          <= res_w;
        D_IN0:   in0_r        <= res_w;
        D_SA:    sa_r         <= res_w;
        D_OUT:   out_sample_r <= clamped[SAMPLE_W-1:0];
        default: ;
      endcase
      if (ctrl_i.mul_en) begin
        prod_r <= prod_w;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;

endmodule

>>> sv/resonant_multipole_clip_filter_top.sv
// top level of the resonant multipole clip filter
// Takes one signed q1.15 sample per word and returns one filtered q1.15 sample.
// A 23-step microcode program runs every sample through one shared adder with
// clamps and one shared multiplier: the idle step takes the word, then 22 steps
// compute it, and no new word is taken before idle. The output word sits in its
// own register; the last step waits only while a previous result is not taken.
// Coefficient and resonance registers must be written through the cfg port while
// the filter is idle (not enforced by the block); no clearing pass follows reset.
module resonant_multipole_clip_filter_top #(
  parameter int INTERNAL_WIDTH = rmcf_pkg::INTERNAL_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [rmcf_pkg::SAMPLE_W-1:0] in_sample_in,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [rmcf_pkg::SAMPLE_W-1:0] out_sample_out,
  input  logic                                 cfg_wr_en,
  input  logic [rmcf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [rmcf_pkg::COEF_W-1:0]          cfg_data
);
  import rmcf_pkg::*;

  logic [STEP_W-1:0] step;
  ctrl_t             ctrl;
  seq_ctl_t          seq;
  logic              out_busy;

  rmcf_ucode_rom u_rom (
    .step_i (step),
    .ctrl_o (ctrl)
  );

  rmcf_sequencer u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl_i     (ctrl),
    .in_valid   (in_valid),
    .out_busy_i (out_busy),
    .in_ready   (in_ready),
    .step_o     (step),
    .seq_o      (seq)
  );

  rmcf_datapath #(
    .INTERNAL_WIDTH (INTERNAL_WIDTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctrl_i         (ctrl),
    .seq_i          (seq),
    .in_sample_in   (in_sample_in),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .out_sample_out (out_sample_out),
    .out_busy_o     (out_busy)
  );

endmodule
